// File: hdl/lcz_pkg.sv
// shared types, constants and register map of the zero-padded line convolution
`timescale 1ns / 1ps

package lcz_pkg;

  localparam int DEF_MAX_RADIUS = 2;
  localparam int DEF_MAX_LINE   = 1024;

  localparam int SAMPLE_W    = 16;
  localparam int PROD_W      = 2 * SAMPLE_W;
  localparam int LEN_CFG_W   = 11;
  localparam int RAD_W       = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int NUM_COEFFS  = 5;
  localparam int COEFF_IDX_W = 3;
  localparam int TAP_CENTRE  = 2;
  localparam int ROUND_SHIFT = 14;
  localparam int ROUND_BIAS  = 8192;
  localparam int SAT_MAX     = 32767;
  localparam int SAT_MIN     = -32768;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_0     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_4     = 3'd6;

  // reset values
  localparam logic [LEN_CFG_W-1:0] RST_LINE_LENGTH = 11'd1024;
  localparam logic [RAD_W-1:0]     RST_RADIUS      = 2'd1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  localparam sample_t RST_COEFF [NUM_COEFFS] = '{
    16'sd0, 16'sd4096, 16'sd8192, 16'sd4096, 16'sd0
  };

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } lcz_state_t;

  // window update issued by the sequencer
  typedef struct packed {
    logic shift;
    logic clear;
    logic zero;
  } lcz_step_t;

  // per-cell controls
  typedef struct packed {
    logic shift;
    logic clear;
    logic load;
  } lcz_cell_ctl_t;

  // tag that travels with a result down the pipeline
  typedef struct packed {
    logic valid;
    logic done;
  } lcz_flag_t;

endpackage

// File: hdl/lcz_cell.sv
// one window cell: a held sample, its tap weight product
`timescale 1ns / 1ps

module lcz_cell
  import lcz_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  lcz_cell_ctl_t ctl,
  input  sample_t       d_in,
  input  sample_t       weight,
  output sample_t       q,
  output prod_t         prod
);

  sample_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (ctl.shift) begin
      held <= ctl.clear ? '0 : d_in;
    end
  end

  // product register, no reset needed
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod <= held * weight;
    end
  end

  assign q = held;

endmodule

// File: hdl/lcz_ctrl.sv
// line position counter and end-of-line flush sequencer
`timescale 1ns / 1ps

module lcz_ctrl
  import lcz_pkg::*;
#(
  parameter int MAX_LINE = DEF_MAX_LINE
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [LEN_CFG_W-1:0] line_length,
  input  logic [RAD_W-1:0]     r_eff,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 ready2,
  output lcz_step_t            step,
  output lcz_flag_t            flag1
);

  localparam int POS_W  = $clog2(MAX_LINE);
  localparam int MAXL_W = $clog2(MAX_LINE + 1);
  localparam int CMP_W  = ((LEN_CFG_W > MAXL_W) ? LEN_CFG_W : MAXL_W) + 1;

  lcz_state_t       state, state_next;
  logic [POS_W-1:0] position, position_next;
  logic [RAD_W-1:0] flush_cnt, flush_cnt_next;
  logic [RAD_W-1:0] flush_thr, flush_thr_next;
  logic             clear_pending, clear_pending_next;
  lcz_flag_t        flag1_next;

  logic             ready1;
  logic [CMP_W-1:0] eff_len;
  logic             last;
  logic             past_radius;
  logic             ev_emit;
  logic             ev_done;
  logic             ev_final;

  always_comb begin
    eff_len = CMP_W'(line_length);
    if (eff_len == '0) begin
      eff_len = CMP_W'(1);
    end else if (eff_len > CMP_W'(MAX_LINE)) begin
      eff_len = CMP_W'(MAX_LINE);
    end
  end

  assign last        = (CMP_W'(position) + CMP_W'(1)) >= eff_len;
  assign past_radius = CMP_W'(position) >= CMP_W'(r_eff);
  assign ready1      = !flag1.valid || ready2;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_RUN;
      position      <= '0;
      flush_cnt     <= '0;
      flush_thr     <= '0;
      clear_pending <= 1'b0;
      flag1         <= '0;
    end else begin
      state         <= state_next;
      position      <= position_next;
      flush_cnt     <= flush_cnt_next;
      flush_thr     <= flush_thr_next;
      clear_pending <= clear_pending_next;
      flag1         <= flag1_next;
    end
  end

  always_comb begin
    state_next         = state;
    position_next      = position;
    flush_cnt_next     = flush_cnt;
    flush_thr_next     = flush_thr;
    clear_pending_next = clear_pending;
    flag1_next         = flag1;
    step               = '0;
    in_ready           = 1'b0;
    ev_emit            = 1'b0;
    ev_done            = 1'b0;
    ev_final           = 1'b0;

    unique case (state)
      ST_RUN: begin
        in_ready = ready1;
        if (in_valid && ready1) begin
          step.shift = 1'b1;
          step.clear = clear_pending;
          ev_emit    = past_radius;
          if (last) begin
            position_next = '0;
            ev_done       = (r_eff == '0);
            if (r_eff == '0) begin
              ev_final = 1'b1;
            end else begin
              // zero pushes stand in for the neighbours past the line end
              state_next     = ST_FLUSH;
              flush_cnt_next = RAD_W'(1);
              flush_thr_next = past_radius ? '0 : (r_eff - RAD_W'(position));
            end
          end else begin
            position_next = position + POS_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (ready1) begin
          step.shift = 1'b1;
          step.zero  = 1'b1;
          ev_emit    = flush_cnt >= flush_thr;
          ev_done    = flush_cnt == r_eff;
          if (flush_cnt == r_eff) begin
            state_next = ST_RUN;
            ev_final   = 1'b1;
          end else begin
            flush_cnt_next = flush_cnt + RAD_W'(1);
          end
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase

    // window is wiped on the first push of the following line
    if (step.shift) begin
      clear_pending_next = ev_final;
    end

    if (ready1) begin
      flag1_next.valid = step.shift && ev_emit;
      flag1_next.done  = ev_done;
    end
  end

endmodule

// File: hdl/lcz_sum.sv
// product sum, rounding and saturation, output register
`timescale 1ns / 1ps

module lcz_sum
  import lcz_pkg::*;
#(
  parameter int NUM = 2 * DEF_MAX_RADIUS + 1
) (
  input  logic      clk,
  input  logic      rst,
  input  prod_t     prod [NUM],
  input  lcz_flag_t flag2,
  output logic      ready3,
  output logic      out_valid,
  input  logic      out_ready,
  output sample_t   out_value,
  output logic      out_done
);

  localparam int SUM_W = PROD_W + $clog2(NUM);

  logic signed [SUM_W-1:0] total;
  logic signed [SUM_W-1:0] sum_r;
  lcz_flag_t               flag3;
  logic                    ready_out;
  logic signed [SUM_W:0]   biased;
  logic signed [SUM_W:0]   scaled;
  sample_t                 sat;

  always_comb begin
    total = '0;
    for (int i = 0; i < NUM; i++) begin
      total = total + SUM_W'(prod[i]);
    end
  end

  assign ready_out = !out_valid || out_ready;
  assign ready3    = !flag3.valid || ready_out;

  // nearest, ties upward
  assign biased = (SUM_W + 1)'(sum_r) + (SUM_W + 1)'(ROUND_BIAS);
  assign scaled = biased >>> ROUND_SHIFT;

  always_comb begin
    if (scaled > (SUM_W + 1)'(SAT_MAX)) begin
      sat = sample_t'(SAT_MAX);
    end else if (scaled < (SUM_W + 1)'(SAT_MIN)) begin
      sat = sample_t'(SAT_MIN);
    end else begin
      sat = scaled[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag3     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ready3) begin
        flag3 <= flag2;
      end
      if (ready_out) begin
        out_valid <= flag3.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready3) begin
      sum_r <= total;
    end
    if (ready_out) begin
      out_value <= sat;
      out_done  <= flag3.done;
    end
  end

endmodule

// File: hdl/line_convolution_zero_padded_top.sv
// top level of the zero-padded line convolution
`timescale 1ns / 1ps

// Zero-padded 1-D FIR along a line of samples, signed Q1.14 in and out.
// s_axis carries one sample per request, in line order; m_axis returns the
// filtered values, tlast marking the final position of each line.
// Registers must be written through cfg_write/cfg_index/cfg_data only while
// no request is in flight; the block has no guard for this. Index 0 line
// length, 1 radius, 2..6 tap weights. A row of 2*MAX_RADIUS+1 cells holds
// the window; every cell shifts its sample to the next one and forms its
// own product, a sum stage adds the products, and rounding logic feeds
// the output register. m_axis_tvalid follows a request through the cell,
// product, sum and output registers. Throughput: one sample per cycle while
// the output does not stall; after the last sample of a line the window
// takes one zero push per step of the clamped radius, with s_axis_tready low.
// Reset (rst, synchronous) restores the register defaults, clears the
// window and the position and empties the pipeline.
// A stalled receiver holds the result in the output register; the pipeline
// keeps taking samples until its stages fill, then s_axis_tready drops.

module line_convolution_zero_padded_top
  import lcz_pkg::*;
#(
  parameter int MAX_RADIUS = DEF_MAX_RADIUS,
  parameter int MAX_LINE   = DEF_MAX_LINE
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // sample requests
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  sample_t               s_axis_tdata,   // [15:0] sample
  // results
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output sample_t               m_axis_tdata,   // [15:0] filtered_value
  output logic                  m_axis_tlast    // line_done
);

  localparam int WIN   = 2 * MAX_RADIUS + 1;
  // only five tap weights exist, so the radius stops at the centre tap
  localparam int R_LIM = (MAX_RADIUS < TAP_CENTRE) ? MAX_RADIUS : TAP_CENTRE;

  // configuration registers
  logic [LEN_CFG_W-1:0] line_length;
  logic [RAD_W-1:0]     radius;
  sample_t              coeff [NUM_COEFFS];
  logic [COEFF_IDX_W-1:0] cfg_coeff_idx;

  assign cfg_coeff_idx = cfg_index - REG_COEFF_0;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= RST_LINE_LENGTH;
      radius      <= RST_RADIUS;
      coeff       <= RST_COEFF;
    end else if (cfg_write) begin
      unique case (cfg_index) inside
        REG_LINE_LENGTH: line_length <= cfg_data[LEN_CFG_W-1:0];
        REG_RADIUS:      radius      <= cfg_data[RAD_W-1:0];
        [REG_COEFF_0:REG_COEFF_4]: coeff[cfg_coeff_idx] <= sample_t'(cfg_data);
        default: begin
          // unmapped index, ignored
        end
      endcase
    end
  end

  logic [RAD_W-1:0] r_eff;
  assign r_eff = (radius > RAD_W'(R_LIM)) ? RAD_W'(R_LIM) : radius;

  // sequencer
  lcz_step_t step;
  lcz_flag_t flag1;
  lcz_flag_t flag2;
  logic      ready2;
  logic      ready3;

  lcz_ctrl #(
    .MAX_LINE (MAX_LINE)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .line_length (line_length),
    .r_eff       (r_eff),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .ready2      (ready2),
    .step        (step),
    .flag1       (flag1)
  );

  // product stage tag; products sit in the cells
  assign ready2 = !flag2.valid || ready3;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag2 <= '0;
    end else if (ready2) begin
      flag2 <= flag1;
    end
  end

  // row of window cells, newest sample in cell 0
  sample_t cell_q  [WIN];
  prod_t   prod    [WIN];

  logic [COEFF_IDX_W-1:0] tap_top;
  logic [COEFF_IDX_W-1:0] tap_span;
  assign tap_top  = COEFF_IDX_W'(r_eff) + COEFF_IDX_W'(TAP_CENTRE);
  assign tap_span = {r_eff, 1'b0};

  for (genvar k = 0; k < WIN; k++) begin : g_cell
    sample_t       weight;
    sample_t       d_in;
    lcz_cell_ctl_t ctl;

    // cell k holds the sample k places back: weight at offset radius-k
    always_comb begin
      if (COEFF_IDX_W'(k) <= tap_span) begin
        weight = coeff[tap_top - COEFF_IDX_W'(k)];
      end else begin
        weight = '0;
      end
    end

    if (k == 0) begin : g_head
      assign d_in      = step.zero ? '0 : s_axis_tdata;
      assign ctl.clear = 1'b0;
    end else begin : g_body
      assign d_in      = cell_q[k-1];
      assign ctl.clear = step.clear;
    end

    assign ctl.shift = step.shift;
    assign ctl.load  = ready2;

    lcz_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .d_in   (d_in),
      .weight (weight),
      .q      (cell_q[k]),
      .prod   (prod[k])
    );
  end

  lcz_sum #(
    .NUM (WIN)
  ) u_sum (
    .clk       (clk),
    .rst       (rst),
    .prod      (prod),
    .flag2     (flag2),
    .ready3    (ready3),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_value (m_axis_tdata),
    .out_done  (m_axis_tlast)
  );

endmodule

// File: bench/tb_line_convolution_zero_padded_top.sv
// self-checking testbench for the zero-padded line convolution top level
`timescale 1ns / 1ps

module tb_line_convolution_zero_padded_top;
  import lcz_pkg::*;

  localparam int HALF_PERIOD     = 4;
  localparam int RESET_CYCLES    = 11;
  localparam int RANDOM_ITEMS    = 440;   // samples in the random part
  localparam int QUIET_FROM      = 380;   // no idling on either side from here on
  localparam int LONG_LINE_AT    = 200;   // one clamped-length run is slotted in here
  localparam int LONG_LINE_ITEMS = 120;   // samples of that run, stops mid-line
  localparam int SETTLE_CYCLES   = 8;     // covers the result latency
  localparam int DRAIN_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT  = 1000;  // cycles without any request moving

  localparam int PRED_MAX_RADIUS = DEF_MAX_RADIUS;
  localparam int PRED_MAX_LINE   = DEF_MAX_LINE;
  localparam int WIN_LEN         = 2 * PRED_MAX_RADIUS + 1;

  // tap weight registers between the two ends named in the package
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_1 = REG_COEFF_0 + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_2 = REG_COEFF_0 + 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_3 = REG_COEFF_0 + 3'd3;
  // index past the register map, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;

  typedef enum logic {
    ROW_CFG,
    ROW_SAMPLE
  } row_kind_t;

  // one row of the directed table; data is the register value or the sample
  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DATA_W-1:0]    data;
    logic                     typed;
    sample_t                  want_value;
    logic                     want_done;
  } dir_row_t;

  typedef struct packed {
    sample_t value;
    logic    done;
  } filt_res_t;

  // dut ports, inputs all driven to known values from time zero
  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  cfg_write     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  sample_t               s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  sample_t               m_axis_tdata;
  logic                  m_axis_tlast;

  line_convolution_zero_padded_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),    // [15:0] sample
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),    // [15:0] filtered_value
    .m_axis_tlast  (m_axis_tlast)     // line_done
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------
  // line filter model: register copies, sample window and line position
  // ---------------------------------------------------------------------
  logic [LEN_CFG_W-1:0] len_reg;
  logic [RAD_W-1:0]     rad_reg;
  sample_t              tap_w [NUM_COEFFS];
  sample_t              win   [WIN_LEN];     // newest sample first
  int unsigned          line_pos;

  filt_res_t pending_filtered [$];   // filtered values still owed by the dut
  filt_res_t step_out [$];           // what the latest sample produced

  dir_row_t  dir_rows [$];
  int        mismatches   = 0;
  int        rand_items   = 0;
  int        stuck_cycles = 0;
  int        ready_hold   = 0;
  bit        quiet        = 1'b0;

  // mirror a register write; upper data bits beyond a register's width drop
  task automatic apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == REG_LINE_LENGTH)
      len_reg = val[LEN_CFG_W-1:0];
    else if (idx == REG_RADIUS)
      rad_reg = val[RAD_W-1:0];
    else if (idx >= REG_COEFF_0 && idx <= REG_COEFF_4)
      tap_w[idx - REG_COEFF_0] = sample_t'(val);
  endtask

  // weighted sum for the position lying lag places behind the newest sample,
  // exact sum, round half up to Q1.14, then saturate
  function automatic sample_t tap_sum(int lag, int r);
    longint acc;
    longint q;
    int     k;
    int     t;
    acc = 0;
    for (t = -r; t <= r; t++) begin
      k = lag - t;
      if (k >= 0 && k < WIN_LEN)
        acc += longint'(tap_w[TAP_CENTRE + t]) * longint'(win[k]);
    end
    q = (acc + ROUND_BIAS) >>> ROUND_SHIFT;
    if (q > SAT_MAX) q = SAT_MAX;
    if (q < SAT_MIN) q = SAT_MIN;
    return sample_t'(q);
  endfunction

  // push one sample through the window and collect the results it releases
  task automatic convolve_step(sample_t x);
    int unsigned r;
    int unsigned len;
    int unsigned lag;
    int          i;
    r = rad_reg;
    if (r > PRED_MAX_RADIUS) r = PRED_MAX_RADIUS;
    if (r > 2) r = 2;               // only five tap weights exist
    len = len_reg;
    if (len == 0) len = 1;
    if (len > PRED_MAX_LINE) len = PRED_MAX_LINE;
    step_out.delete();
    for (i = WIN_LEN - 1; i > 0; i--)
      win[i] = win[i - 1];
    win[0] = x;
    if (line_pos + 1 >= len) begin
      // last sample of the line: flush the tail, at most r+1 results
      lag = (line_pos < r) ? line_pos : r;
      forever begin
        step_out.push_back('{value: tap_sum(lag, r), done: (lag == 0)});
        if (lag == 0) break;
        lag--;
      end
      for (i = 0; i < WIN_LEN; i++)
        win[i] = '0;
      line_pos = 0;
    end else begin
      if (line_pos >= r)
        step_out.push_back('{value: tap_sum(r, r), done: 1'b0});
      line_pos = line_pos + 1;
    end
  endtask

  // ---------------------------------------------------------------------
  // driving helpers; all run from one edge to the next
  // ---------------------------------------------------------------------

  // drop valid and hold until every owed result is back and the pipe is empty
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_filtered.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write; write enable drops and an idle wait follows, keeping
  // write enable to one assignment per step
  task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    apply_cfg(idx, val);
    @(posedge clk);
  endtask

  // offer one sample request; once it is taken, book what it should produce
  task automatic send_sample(sample_t x, bit typed, sample_t want_value, logic want_done);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    convolve_step(x);
    if (typed)
      pending_filtered.push_back('{value: want_value, done: want_done});
    else
      foreach (step_out[i]) pending_filtered.push_back(step_out[i]);
  endtask

  // sender gap now and then, unless quiet or calm
  task automatic maybe_pause(bit calm);
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7)) inside
      0:       return sample_t'(SAT_MAX);
      1:       return sample_t'(SAT_MIN);
      2, 3:    return sample_t'(int'($urandom_range(0, 2048)) - 1024);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_coeff();
    case ($urandom_range(0, 5)) inside
      0:       return CFG_DATA_W'(SAT_MAX);
      1:       return CFG_DATA_W'(SAT_MIN);
      2, 3:    return CFG_DATA_W'(int'($urandom_range(0, 16384)) - 8192);
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // new settings while idle, then a run of samples that may stop mid-line
  task automatic run_phase(bit long_line);
    int len;
    int eff;
    int n;
    int k;
    bit calm;
    wait_idle();
    if (long_line)
      len = 2047;                   // above the line limit, clamps to it
    else
      case ($urandom_range(0, 9)) inside
        0:          len = 0;
        7, 8:       len = $urandom_range(9, 40);
        9:          len = $urandom_range(1, 3);
        default:    len = $urandom_range(1, 8);
      endcase
    cfg_put(REG_LINE_LENGTH, {5'($urandom), 11'(len)});
    cfg_put(REG_RADIUS, {14'($urandom), 2'($urandom_range(0, 3))});
    for (k = 0; k < NUM_COEFFS; k++)
      cfg_put(CFG_IDX_W'(REG_COEFF_0 + k), pick_coeff());
    if ($urandom_range(0, 7) == 0)
      cfg_put(REG_UNUSED, CFG_DATA_W'($urandom));
    eff = (len == 0) ? 1 : (len > PRED_MAX_LINE) ? PRED_MAX_LINE : len;
    n = long_line ? LONG_LINE_ITEMS : eff * $urandom_range(1, 4) + $urandom_range(0, 2);
    calm = ($urandom_range(0, 2) == 0);
    for (k = 0; k < n; k++) begin
      maybe_pause(calm);
      send_sample(pick_sample(), 1'b0, '0, 1'b0);
      rand_items++;
    end
  endtask

  function automatic dir_row_t row_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    return '{ROW_CFG, idx, val, 1'b0, '0, 1'b0};
  endfunction

  function automatic dir_row_t row_smp(sample_t x);
    return '{ROW_SAMPLE, '0, x, 1'b0, '0, 1'b0};
  endfunction

  function automatic dir_row_t row_chk(sample_t x, sample_t v, logic d);
    return '{ROW_SAMPLE, '0, x, 1'b1, v, d};
  endfunction

  // ---------------------------------------------------------------------
  // receiver: ready held in bursts with stalls between, none when quiet
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (quiet || $urandom_range(0, 2) != 0) begin
      m_axis_tready <= 1'b1;
      ready_hold    <= $urandom_range(0, ($urandom_range(0, 5) == 0) ? 40 : 5);
    end else begin
      m_axis_tready <= 1'b0;
      ready_hold    <= $urandom_range(0, 5);
    end
  end

  // result checker: each result against the oldest owed one
  always @(posedge clk) begin : check_results
    filt_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_filtered.size() == 0) begin
        $error("unexpected result: filtered_value %0d line_done %0b",
               m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        want = pending_filtered.pop_front();
        if (m_axis_tdata !== want.value) begin
          $error("filtered_value: expected %0d, got %0d", want.value, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tlast !== want.done) begin
          $error("line_done: expected %0b, got %0b", want.done, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long without any request, result or register write moving
  always @(posedge clk) begin
    if (rst || cfg_write || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    bit long_done;
    long_done = 1'b0;

    // model starts from the reset state of the block
    len_reg  = RST_LINE_LENGTH;
    rad_reg  = RST_RADIUS;
    tap_w    = RST_COEFF;
    line_pos = 0;
    foreach (win[i]) win[i] = '0;

    // two samples at the reset settings, then a length change mid-line,
    // so the next sample closes the line
    dir_rows.push_back(row_smp(16'sd16384));
    dir_rows.push_back(row_smp(16'sd16384));
    dir_rows.push_back(row_cfg(REG_LINE_LENGTH, 16'd1));
    dir_rows.push_back(row_cfg(REG_RADIUS, 16'd0));
    // unit gain, single tap: output equals input
    dir_rows.push_back(row_cfg(REG_COEFF_2, 16'd16384));
    dir_rows.push_back(row_chk(16'sd32767, 16'sd32767, 1'b1));
    dir_rows.push_back(row_chk(-16'sd32768, -16'sd32768, 1'b1));
    dir_rows.push_back(row_chk(16'sd0, 16'sd0, 1'b1));
    dir_rows.push_back(row_chk(16'sd1, 16'sd1, 1'b1));
    // half gain: ties go towards plus infinity
    dir_rows.push_back(row_cfg(REG_COEFF_2, 16'd8192));
    dir_rows.push_back(row_chk(16'sd1, 16'sd1, 1'b1));
    dir_rows.push_back(row_chk(-16'sd1, 16'sd0, 1'b1));
    dir_rows.push_back(row_chk(16'sd3, 16'sd2, 1'b1));
    // gain of minus two: saturation at both ends
    dir_rows.push_back(row_cfg(REG_COEFF_2, 16'h8000));
    dir_rows.push_back(row_chk(-16'sd32768, 16'sd32767, 1'b1));
    dir_rows.push_back(row_chk(16'sd32767, -16'sd32768, 1'b1));
    // zero length behaves as one
    dir_rows.push_back(row_cfg(REG_LINE_LENGTH, 16'd0));
    dir_rows.push_back(row_smp(16'sd12345));
    // index outside the map, upper data bits set, radius above the limit
    dir_rows.push_back(row_cfg(REG_UNUSED, 16'hFFFF));
    dir_rows.push_back(row_cfg(REG_LINE_LENGTH, 16'hF803));
    dir_rows.push_back(row_cfg(REG_RADIUS, 16'hFFFF));
    dir_rows.push_back(row_cfg(REG_COEFF_0, 16'd16384));
    dir_rows.push_back(row_cfg(REG_COEFF_1, 16'hC000));
    dir_rows.push_back(row_cfg(REG_COEFF_2, 16'd16384));
    dir_rows.push_back(row_cfg(REG_COEFF_3, 16'h7FFF));
    dir_rows.push_back(row_cfg(REG_COEFF_4, 16'h8000));
    // short lines, shorter than the kernel is wide
    dir_rows.push_back(row_smp(16'sd1000));
    dir_rows.push_back(row_smp(-16'sd2000));
    dir_rows.push_back(row_smp(16'sd3000));
    dir_rows.push_back(row_smp(-16'sd32768));
    dir_rows.push_back(row_smp(16'sd32767));
    dir_rows.push_back(row_smp(-16'sd32768));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_idle();
        cfg_put(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        maybe_pause(1'b0);
        send_sample(sample_t'(dir_rows[i].data), dir_rows[i].typed,
                    dir_rows[i].want_value, dir_rows[i].want_done);
      end
    end

    // random phases, mostly short lines, one clamped-length run in the middle
    while (rand_items < RANDOM_ITEMS) begin
      if (rand_items >= QUIET_FROM) quiet = 1'b1;
      if (!long_done && rand_items >= LONG_LINE_AT) begin
        run_phase(1'b1);
        long_done = 1'b1;
      end else begin
        run_phase(1'b0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
